FILE: hw/rtl/ble_pkg.sv
// Package: shared types and constants for the bully leader election node.
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

    // Identifier width, fixed by the message format.
    localparam int ID_BITS = 8;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_ID        = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RTT_TICKS      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROBE_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORMAL_TIMEOUT = 2'd3;

    // Register values after reset.
    localparam logic [ID_BITS-1:0] NODE_ID_RST        = 8'd0;
    localparam logic [15:0]        RTT_TICKS_RST      = 16'd100;
    localparam logic [23:0]        PROBE_PERIOD_RST   = 24'd1000;
    localparam logic [23:0]        NORMAL_TIMEOUT_RST = 24'd4000;

    // Item kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_MESSAGE = 1'b1;

    // Message types.
    localparam logic [2:0] MSG_ARE_U_THERE  = 3'd0;
    localparam logic [2:0] MSG_YES          = 3'd1;
    localparam logic [2:0] MSG_HALT         = 3'd2;
    localparam logic [2:0] MSG_NEW_LEADER   = 3'd3;
    localparam logic [2:0] MSG_ARE_U_NORMAL = 3'd4;
    localparam logic [2:0] MSG_STATE        = 3'd5;

    // Election sequencer steps.
    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_FIRST    = 6'b000010,
        PH_PROBED   = 6'b000100,
        PH_PRE_HALT = 6'b001000,
        PH_HALTED   = 6'b010000,
        PH_RETRY    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [2:0]         msg_type;
        logic [ID_BITS-1:0] sender_id;
        logic [7:0]         payload;
    } in_item_t;

    typedef struct packed {
        logic               send_valid;
        logic               send_multicast;
        logic [ID_BITS-1:0] send_dest;
        logic [2:0]         send_type;
        logic [7:0]         send_payload;
        logic               leader_known;
        logic [ID_BITS-1:0] leader_value;
        logic               in_election;
        logic               strongest_now;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bully_leader_election_top.sv
// Top level: one node of a bully leader election, one item per cycle while the result side keeps up.
//
//  Channel  Ports                                 Direction  Carries
//  s_       s_valid, s_ready, s_data              in         tick or received message
//  m_       m_valid, m_ready, m_data              out        outgoing message and status
//  cfg_     cfg_we, cfg_index, cfg_wdata          in         register writes, no read-back
//
//  Cycles: one item per cycle sustained while m_ready stays high; an input transaction reaches
//  the result through the input register, the update logic and the result register.
//  Reset: aresetn is synchronous and active low; it restores the register defaults
//  and the election state (election mode, strongest, no leader, first 2-RTT wait).
//  Stalls: a waiting result holds the input register, which in turn drops s_ready.
`timescale 1ns / 1ps
`default_nettype none

module bully_leader_election_top #(
    parameter int TIME_BITS = 32
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  ble_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output ble_pkg::out_item_t                   m_data,
    input  wire                                  cfg_we,
    input  wire  [ble_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [ble_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    import ble_pkg::*;

    // Width for comparing elapsed ticks with the 24-bit period registers.
    localparam int CMP_BITS = (TIME_BITS > 24) ? TIME_BITS : 24;

    // Configuration registers.
    logic [ID_BITS-1:0] node_id_reg;
    logic [15:0]        rtt_ticks_reg;
    logic [23:0]        probe_period_reg;
    logic [23:0]        normal_timeout_reg;

    // Election state.
    logic                 mode_reg,      mode_next;
    logic                 strong_reg,    strong_next;
    logic                 lvalid_reg,    lvalid_next;
    logic [ID_BITS-1:0]   leader_reg,    leader_next;
    phase_t               phase_reg,     phase_next;
    logic [17:0]          wait_reg,      wait_next;
    logic [TIME_BITS-1:0] tick_reg,      tick_next;
    logic [TIME_BITS-1:0] seen_reg,      seen_next;
    logic [TIME_BITS-1:0] sent_reg,      sent_next;
    logic                 psent_reg,     psent_next;

    // Input register and result register.
    logic      in_valid_reg;
    in_item_t  in_reg;
    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t result;

    logic proc_fire;

    // Helpers for the update logic.
    logic [TIME_BITS-1:0] tick_inc;
    logic [TIME_BITS-1:0] el_sent;
    logic [TIME_BITS-1:0] el_seen;
    logic [17:0]          rtt2;
    logic [17:0]          rtt3;
    logic [17:0]          target;
    logic [17:0]          wait_inc;
    logic                 is_leader;

    // Process the held item whenever the result register is free or being drained.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign tick_inc  = tick_reg + TIME_BITS'(1);
    assign el_sent   = tick_inc - sent_reg;
    assign el_seen   = tick_inc - seen_reg;
    assign rtt2      = {1'b0, rtt_ticks_reg, 1'b0};
    assign rtt3      = {2'b00, rtt_ticks_reg} + rtt2;
    assign wait_inc  = wait_reg + 18'd1;
    assign is_leader = lvalid_reg && (leader_reg == node_id_reg);

    // Pick the length of the current sequencer wait.
    always_comb begin
        case (phase_reg)
            PH_HALTED: target = {2'b00, rtt_ticks_reg};
            PH_RETRY:  target = rtt3;
            default:   target = rtt2;
        endcase
    end

    // Next state and result for the item in the input register.
    always_comb begin
        mode_next   = mode_reg;
        strong_next = strong_reg;
        lvalid_next = lvalid_reg;
        leader_next = leader_reg;
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        tick_next   = tick_reg;
        seen_next   = seen_reg;
        sent_next   = sent_reg;
        psent_next  = psent_reg;

        result = '0;

        if (in_reg.kind == KIND_TICK) begin
            tick_next = tick_inc;
            if (phase_reg != PH_IDLE) begin
                // Advance the wait; act only when it expires.
                if (wait_inc < target) begin
                    wait_next = wait_inc;
                end else begin
                    wait_next = '0;
                    case (phase_reg)
                        PH_FIRST: begin
                            if (strong_reg) begin
                                mode_next             = 1'b1;
                                result.send_valid     = 1'b1;
                                result.send_multicast = 1'b1;
                                result.send_type      = MSG_ARE_U_THERE;
                                result.send_payload   = node_id_reg;
                                phase_next            = PH_PROBED;
                            end else begin
                                phase_next = PH_RETRY;
                            end
                        end
                        PH_PROBED: begin
                            phase_next = strong_reg ? PH_PRE_HALT : PH_RETRY;
                        end
                        PH_PRE_HALT: begin
                            result.send_valid     = 1'b1;
                            result.send_multicast = 1'b1;
                            result.send_type      = MSG_HALT;
                            phase_next            = PH_HALTED;
                        end
                        PH_HALTED: begin
                            result.send_valid     = 1'b1;
                            result.send_multicast = 1'b1;
                            result.send_type      = MSG_NEW_LEADER;
                            result.send_payload   = node_id_reg;
                            mode_next             = 1'b0;
                            leader_next           = node_id_reg;
                            lvalid_next           = 1'b1;
                            psent_next            = 1'b0;
                            phase_next            = PH_IDLE;
                        end
                        PH_RETRY: begin
                            phase_next = lvalid_reg ? PH_IDLE : PH_FIRST;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end else begin
                if (is_leader) begin
                    // Periodic liveness probe from the leader.
                    if (!psent_reg ||
                        (CMP_BITS'(el_sent) > CMP_BITS'(probe_period_reg))) begin
                        result.send_valid     = 1'b1;
                        result.send_multicast = 1'b1;
                        result.send_type      = MSG_ARE_U_NORMAL;
                        sent_next             = tick_inc;
                        psent_next            = 1'b1;
                    end
                end else if (CMP_BITS'(el_seen) > CMP_BITS'(normal_timeout_reg)) begin
                    // Leader went quiet: claim strongest and elect.
                    strong_next = 1'b1;
                    mode_next   = 1'b1;
                end
                if (mode_next) begin
                    phase_next = PH_FIRST;
                    wait_next  = '0;
                end
            end
        end else begin
            case (in_reg.msg_type)
                MSG_ARE_U_THERE: begin
                    if ((node_id_reg > in_reg.sender_id) && strong_reg) begin
                        result.send_valid = 1'b1;
                        result.send_dest  = in_reg.sender_id;
                        result.send_type  = MSG_YES;
                        mode_next         = 1'b1;
                    end else begin
                        strong_next = 1'b0;
                    end
                end
                MSG_YES: begin
                    mode_next   = 1'b0;
                    strong_next = 1'b0;
                end
                MSG_HALT: begin
                    mode_next = 1'b1;
                end
                MSG_NEW_LEADER: begin
                    seen_next   = tick_reg;
                    leader_next = in_reg.payload;
                    lvalid_next = 1'b1;
                    mode_next   = 1'b0;
                end
                MSG_ARE_U_NORMAL: begin
                    seen_next           = tick_reg;
                    result.send_valid   = 1'b1;
                    result.send_dest    = in_reg.sender_id;
                    result.send_type    = MSG_STATE;
                    result.send_payload = {7'd0, mode_reg};
                end
                MSG_STATE: begin
                    if (in_reg.payload != 8'd0) begin
                        mode_next = 1'b1;
                    end
                end
                default: begin
                    // Unknown types are dropped.
                end
            endcase
        end

        // Status reflects the state after the item.
        result.leader_known  = lvalid_next;
        result.leader_value  = leader_next;
        result.in_election   = mode_next;
        result.strongest_now = strong_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg        <= NODE_ID_RST;
            rtt_ticks_reg      <= RTT_TICKS_RST;
            probe_period_reg   <= PROBE_PERIOD_RST;
            normal_timeout_reg <= NORMAL_TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NODE_ID:        node_id_reg        <= cfg_wdata[ID_BITS-1:0];
                CFG_RTT_TICKS:      rtt_ticks_reg      <= cfg_wdata[15:0];
                CFG_PROBE_PERIOD:   probe_period_reg   <= cfg_wdata[23:0];
                CFG_NORMAL_TIMEOUT: normal_timeout_reg <= cfg_wdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Election state: commit on each processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b1;
            strong_reg <= 1'b1;
            lvalid_reg <= 1'b0;
            leader_reg <= '0;
            phase_reg  <= PH_FIRST;
            wait_reg   <= '0;
            tick_reg   <= '0;
            seen_reg   <= '0;
            sent_reg   <= '0;
            psent_reg  <= 1'b0;
        end else if (proc_fire) begin
            mode_reg   <= mode_next;
            strong_reg <= strong_next;
            lvalid_reg <= lvalid_next;
            leader_reg <= leader_next;
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            tick_reg   <= tick_next;
            seen_reg   <= seen_next;
            sent_reg   <= sent_next;
            psent_reg  <= psent_next;
        end
    end

    // Input register: load on an input transaction, free once processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Result register: hold until the output transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            out_reg <= result;
        end
    end

    // A processed item always lands in the result register.
    a_fire_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    // A blocked item stays put in the input register.
    a_blocked_item_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_reg)))
        else $error("blocked input item was lost or changed");

    // Once a leader is known it is never forgotten.
    a_leader_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(lvalid_reg))
        else $error("leader_valid dropped");

    // Multicast results carry a message and no destination.
    a_multicast_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.send_multicast) |->
            (out_reg.send_valid && (out_reg.send_dest == '0)))
        else $error("malformed multicast result");

endmodule

`default_nettype wire

FILE: bench/ble_reply_checker.sv
// Reply checker for the bully leader election node: predicts and compares every result.
`timescale 1ns / 1ps

module ble_reply_checker (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    input  wire                                s_ready,
    input  ble_pkg::in_item_t                  s_data,
    input  wire                                m_valid,
    input  wire                                m_ready,
    input  ble_pkg::out_item_t                 m_data,
    input  wire                                cfg_we,
    input  wire  [ble_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire  [ble_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output int                                 fail_count,
    output int                                 replies_pending,
    output int                                 replies_checked,
    output int                                 msgs_seen,
    output int                                 leaders_seen
);

    import ble_pkg::*;

    // Register copies
    logic [7:0]  node_id_q;
    logic [15:0] rtt_q;
    logic [23:0] period_q;
    logic [23:0] timeout_q;

    // Node state
    logic        electing;
    logic        strongest;
    logic        leader_ok;
    logic [7:0]  leader_q;
    phase_t      phase;
    logic [17:0] wait_cnt;
    logic [31:0] tick_now;
    logic [31:0] probe_seen_at;
    logic [31:0] probe_sent_at;
    logic        probe_sent;

    out_item_t   pending_replies[$];
    out_item_t   want;
    int          errors;
    int          checked;
    int          msgs;
    int          leaders;

    initial begin
        errors  = 0;
        checked = 0;
        msgs    = 0;
        leaders = 0;
    end

    task automatic reset_node();
        node_id_q     = NODE_ID_RST;
        rtt_q         = RTT_TICKS_RST;
        period_q      = PROBE_PERIOD_RST;
        timeout_q     = NORMAL_TIMEOUT_RST;
        electing      = 1'b1;
        strongest     = 1'b1;
        leader_ok     = 1'b0;
        leader_q      = '0;
        phase         = PH_FIRST;
        wait_cnt      = '0;
        tick_now      = '0;
        probe_seen_at = '0;
        probe_sent_at = '0;
        probe_sent    = 1'b0;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        errors++;
        if (errors <= 30)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_v);
    endtask

    function automatic out_item_t with_msg(input logic multi, input logic [7:0] dest,
                                           input logic [2:0] mtype, input logic [7:0] pay);
        out_item_t r;
        r = '0;
        r.send_valid     = 1'b1;
        r.send_multicast = multi;
        r.send_dest      = dest;
        r.send_type      = mtype;
        r.send_payload   = pay;
        return r;
    endfunction

    // Next result of the node for one input item; updates the state copy.
    function automatic out_item_t predict_node_reply(input in_item_t it);
        out_item_t   r;
        int unsigned target;
        r = '0;
        if (it.kind == KIND_MESSAGE) begin
            case (it.msg_type)
                MSG_ARE_U_THERE: begin
                    if (node_id_q > it.sender_id && strongest) begin
                        r = with_msg(1'b0, it.sender_id, MSG_YES, 8'd0);
                        electing = 1'b1;
                    end else begin
                        strongest = 1'b0;
                    end
                end
                MSG_YES: begin
                    electing  = 1'b0;
                    strongest = 1'b0;
                end
                MSG_HALT: electing = 1'b1;
                MSG_NEW_LEADER: begin
                    probe_seen_at = tick_now;
                    leader_q      = it.payload;
                    leader_ok     = 1'b1;
                    electing      = 1'b0;
                end
                MSG_ARE_U_NORMAL: begin
                    probe_seen_at = tick_now;
                    r = with_msg(1'b0, it.sender_id, MSG_STATE, {7'd0, electing});
                end
                MSG_STATE: if (it.payload != 8'd0) electing = 1'b1;
                default: ;
            endcase
        end else begin
            tick_now = tick_now + 32'd1;
            if (phase != PH_IDLE) begin
                case (phase)
                    PH_HALTED: target = 32'(rtt_q);
                    PH_RETRY:  target = 3 * rtt_q;
                    default:   target = 2 * rtt_q;
                endcase
                wait_cnt = wait_cnt + 18'd1;
                if (32'(wait_cnt) >= target) begin
                    wait_cnt = '0;
                    case (phase)
                        PH_FIRST: begin
                            if (strongest) begin
                                electing = 1'b1;
                                r = with_msg(1'b1, 8'd0, MSG_ARE_U_THERE, node_id_q);
                                phase = PH_PROBED;
                            end else begin
                                phase = PH_RETRY;
                            end
                        end
                        PH_PROBED:   phase = strongest ? PH_PRE_HALT : PH_RETRY;
                        PH_PRE_HALT: begin
                            r = with_msg(1'b1, 8'd0, MSG_HALT, 8'd0);
                            phase = PH_HALTED;
                        end
                        PH_HALTED: begin
                            r = with_msg(1'b1, 8'd0, MSG_NEW_LEADER, node_id_q);
                            electing   = 1'b0;
                            leader_q   = node_id_q;
                            leader_ok  = 1'b1;
                            probe_sent = 1'b0;
                            phase      = PH_IDLE;
                        end
                        PH_RETRY: phase = leader_ok ? PH_IDLE : PH_FIRST;
                        default:  phase = PH_IDLE;
                    endcase
                end
            end else begin
                if (leader_ok && leader_q == node_id_q) begin
                    if (!probe_sent || (tick_now - probe_sent_at) > 32'(period_q)) begin
                        r = with_msg(1'b1, 8'd0, MSG_ARE_U_NORMAL, 8'd0);
                        probe_sent_at = tick_now;
                        probe_sent    = 1'b1;
                    end
                end else if ((tick_now - probe_seen_at) > 32'(timeout_q)) begin
                    strongest = 1'b1;
                    electing  = 1'b1;
                end
                if (electing) begin
                    phase    = PH_FIRST;
                    wait_cnt = '0;
                end
            end
        end
        r.leader_known  = leader_ok;
        r.leader_value  = leader_q;
        r.in_election   = electing;
        r.strongest_now = strongest;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_node();
            pending_replies.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NODE_ID:        node_id_q = cfg_wdata[7:0];
                    CFG_RTT_TICKS:      rtt_q     = cfg_wdata[15:0];
                    CFG_PROBE_PERIOD:   period_q  = cfg_wdata[23:0];
                    CFG_NORMAL_TIMEOUT: timeout_q = cfg_wdata[23:0];
                    default: ;
                endcase
            end
            // Compare before queuing: no result can belong to an item taken this edge.
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    report("result with nothing expected", m_data, '0);
                end else begin
                    want = pending_replies.pop_front();
                    checked++;
                    if (m_data.send_valid !== want.send_valid)
                        report("send_valid", 32'(m_data.send_valid), 32'(want.send_valid));
                    if (m_data.send_multicast !== want.send_multicast)
                        report("send_multicast", 32'(m_data.send_multicast),
                               32'(want.send_multicast));
                    if (m_data.send_dest !== want.send_dest)
                        report("send_dest", 32'(m_data.send_dest), 32'(want.send_dest));
                    if (m_data.send_type !== want.send_type)
                        report("send_type", 32'(m_data.send_type), 32'(want.send_type));
                    if (m_data.send_payload !== want.send_payload)
                        report("send_payload", 32'(m_data.send_payload),
                               32'(want.send_payload));
                    if (m_data.leader_known !== want.leader_known)
                        report("leader_known", 32'(m_data.leader_known),
                               32'(want.leader_known));
                    if (m_data.leader_value !== want.leader_value)
                        report("leader_value", 32'(m_data.leader_value),
                               32'(want.leader_value));
                    if (m_data.in_election !== want.in_election)
                        report("in_election", 32'(m_data.in_election), 32'(want.in_election));
                    if (m_data.strongest_now !== want.strongest_now)
                        report("strongest_now", 32'(m_data.strongest_now),
                               32'(want.strongest_now));
                    if (want.send_valid)
                        msgs++;
                    if (want.send_valid && want.send_type == MSG_NEW_LEADER)
                        leaders++;
                end
            end
            if (s_valid && s_ready)
                pending_replies.push_back(predict_node_reply(s_data));
        end
        fail_count      <= errors;
        replies_pending <= pending_replies.size();
        replies_checked <= checked;
        msgs_seen       <= msgs;
        leaders_seen    <= leaders;
    end

endmodule

FILE: bench/tb_bully_leader_election_top.sv
// Testbench top for the bully leader election node: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_bully_leader_election_top;
    import ble_pkg::*;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    in_item_t                 s_data;
    logic                     m_valid;
    logic                     m_ready;
    out_item_t                m_data;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    int fail_count;
    int replies_pending;
    int replies_checked;
    int msgs_seen;
    int leaders_seen;

    // Shared with the result-side stall process: idle bursts on or off.
    logic gaps_on;
    int   items_sent;
    int   settings_loaded;

    // Current register values, used only to shape the stimulus.
    logic [7:0]  cur_node;
    logic [15:0] cur_rtt;
    logic [23:0] cur_timeout;

    bully_leader_election_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ble_reply_checker reply_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .replies_pending (replies_pending),
        .replies_checked (replies_checked),
        .msgs_seen       (msgs_seen),
        .leaders_seen    (leaders_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: drop m_ready in random bursts while idling is on.
    initial begin : rx_stalls
        int hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t make_item(input logic kind, input logic [2:0] mtype,
                                           input logic [7:0] src, input logic [7:0] pay);
        in_item_t it;
        it.kind      = kind;
        it.msg_type  = mtype;
        it.sender_id = src;
        it.payload   = pay;
        return it;
    endfunction

    // Pick a sender below, above, equal to, or unrelated to this node's id.
    function automatic logic [7:0] pick_sender();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, cur_node));
            1:       return 8'($urandom_range(cur_node, 255));
            2:       return cur_node;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random received message, weighted toward the traffic a live node sees.
    function automatic in_item_t rand_msg();
        int          pick;
        logic [7:0]  src;
        logic [7:0]  pay;
        logic [2:0]  mtype;
        pick = $urandom_range(0, 99);
        src  = pick_sender();
        pay  = 8'($urandom_range(0, 255));
        if (pick < 15)      mtype = MSG_ARE_U_THERE;
        else if (pick < 22) mtype = MSG_YES;
        else if (pick < 30) mtype = MSG_HALT;
        else if (pick < 42) mtype = MSG_NEW_LEADER;
        else if (pick < 75) mtype = MSG_ARE_U_NORMAL;
        else if (pick < 92) mtype = MSG_STATE;
        else                mtype = 3'($urandom_range(6, 7));   // unknown types
        if (mtype == MSG_NEW_LEADER && $urandom_range(0, 1) == 0)
            pay = src;
        if (mtype == MSG_STATE && $urandom_range(0, 1) == 0)
            pay = 8'd0;
        return make_item(KIND_MESSAGE, mtype, src, pay);
    endfunction

    // Hold valid and payload until the transaction is taken; maybe idle first.
    task automatic send_item(input in_item_t it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Tick: the message fields are don't-care, so fill them with noise.
    task automatic send_tick();
        send_item(make_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255))));
    endtask

    task automatic send_msg(input logic [2:0] mtype, input logic [7:0] src,
                            input logic [7:0] pay);
        send_item(make_item(KIND_MESSAGE, mtype, src, pay));
    endtask

    // Drop valid, wait until every result is back, then let the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all four registers back to back; junk in the unused high bits.
    task automatic load_settings(input logic [7:0] node, input logic [15:0] rtt,
                                 input logic [23:0] period, input logic [23:0] timeout);
        cur_node    = node;
        cur_rtt     = rtt;
        cur_timeout = timeout;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_ID;
        cfg_wdata <= {16'($urandom), node};
        @(posedge aclk);
        cfg_index <= CFG_RTT_TICKS;
        cfg_wdata <= {8'($urandom), rtt};
        @(posedge aclk);
        cfg_index <= CFG_PROBE_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_index <= CFG_NORMAL_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Mostly ticks with an occasional random message, to drive an election round along.
    task automatic run_election();
        int n;
        n = (cur_rtt > 8) ? $urandom_range(10, 40) : $urandom_range(4, 8 * cur_rtt + 8);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_item(rand_msg());
            else
                send_tick();
        end
    endtask

    // A stronger node (any node when this one is 0xFF) takes over, probes for a while, then maybe goes quiet.
    task automatic run_follower();
        logic [7:0] boss;
        int         quiet;
        boss = (cur_node == 8'hFF) ? 8'($urandom) : 8'($urandom_range(cur_node + 1, 255));
        send_msg(MSG_NEW_LEADER, boss, boss);
        repeat ($urandom_range(5, 30)) begin
            send_tick();
            if ($urandom_range(0, 2) == 0)
                send_msg(MSG_ARE_U_NORMAL, boss, 8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 9) == 0)
                send_msg(MSG_STATE, boss, 8'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1) == 0) begin
            quiet = (cur_timeout > 38) ? 40 : cur_timeout + 2;
            repeat (quiet) send_tick();
        end
    endtask

    // Another node challenges: probe, maybe answer or halt, then let time pass.
    task automatic run_challenge();
        logic [7:0] rival;
        rival = pick_sender();
        send_msg(MSG_ARE_U_THERE, rival, rival);
        if ($urandom_range(0, 2) == 0)
            send_msg(MSG_YES, pick_sender(), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
            send_msg(MSG_HALT, rival, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
            send_msg(MSG_STATE, rival, 8'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 12)) send_tick();
    endtask

    task automatic run_noise();
        repeat (8) begin
            if ($urandom_range(0, 1) == 0)
                send_tick();
            else
                send_item(make_item(KIND_MESSAGE, 3'($urandom_range(0, 7)),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255))));
        end
    endtask

    // Random scenarios until the budget is used; idling is picked anew per scenario.
    task automatic run_phase(input int budget, input logic allow_idle);
        int start;
        start = items_sent;
        while (items_sent - start < budget) begin
            gaps_on = allow_idle && ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_election();
                4, 5, 6:    run_follower();
                7, 8:       run_challenge();
                default:    run_noise();
            endcase
        end
    endtask

    initial begin : stimulus
        int p;
        gaps_on         = 1'b0;
        items_sent      = 0;
        settings_loaded = 0;
        cur_node        = NODE_ID_RST;
        cur_rtt         = RTT_TICKS_RST;
        cur_timeout     = NORMAL_TIMEOUT_RST;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_NODE_ID;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a couple of ticks with the reset values, then a fast election.
        send_tick();
        send_tick();
        drain();
        load_settings(8'h80, 16'd1, 24'd3, 24'd5);
        // Probe, halt, announce ourselves, then the first leader probe.
        repeat (8) send_tick();
        send_msg(MSG_ARE_U_THERE, 8'h00, 8'h00);      // weaker node: answer yes
        send_msg(MSG_ARE_U_THERE, 8'hFF, 8'hFF);      // stronger node: give up strongest
        send_msg(MSG_YES, 8'hFF, 8'h00);
        send_msg(MSG_HALT, 8'hFF, 8'h00);
        send_msg(MSG_STATE, 8'h12, 8'h00);            // normal peer: no change
        send_msg(MSG_STATE, 8'h34, 8'hFF);            // peer in election
        send_msg(MSG_ARE_U_NORMAL, 8'hFF, 8'h00);     // reply with our mode
        send_msg(MSG_NEW_LEADER, 8'hFF, 8'hFF);
        send_msg(3'd6, 8'h55, 8'hAA);                 // unknown types: ignore
        send_msg(3'd7, 8'hAA, 8'h55);
        // Ticks as a follower, stopping short of the follower timeout.
        repeat (5) send_tick();

        // Random part: several settings, extremes included.
        for (p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: load_settings(8'hC5, 16'd2, 24'd6, 24'd12);
                1: load_settings(8'h00, 16'd0, 24'd0, 24'd0);           // all zero
                2: load_settings(8'hFF, 16'd3, 24'd10, 24'd25);
                3: load_settings(8'h3A, 16'd1, 24'd1, 24'd2);
                4: load_settings(8'hFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF); // all max
                default: load_settings(8'($urandom_range(0, 255)), 16'($urandom_range(1, 4)),
                                       24'($urandom_range(1, 30)), 24'($urandom_range(1, 60)));
            endcase
            // Slow waits at the max setting: keep that phase short.
            // Last phase runs without idling.
            run_phase((p == 4) ? 120 : 300, p != 5);
        end

        gaps_on = 1'b0;
        drain();
        repeat (6) @(posedge aclk);

        $display("Drove %0d transactions over %0d register settings, idling on both sides.",
                 items_sent, settings_loaded);
        $display("Checked %0d results: %0d outgoing messages, %0d leader announcements.",
                 replies_checked, msgs_seen, leaders_seen);
        if (fail_count == 0 && replies_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
